/* rtl/core/wgma_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgma_pkg: shared types and constants for the weighted global motion average
// Field widths, weighting constants, register indexes and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package wgma_pkg;

	// Field widths
	localparam int VEC_W      = 8;
	localparam int SAD_W      = 16;
	localparam int MEAN_W     = 13;
	localparam int CFG_W      = 8;
	localparam int CFG_ADDR_W = 1;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 32;

	// Default dimension limits
	localparam int DEF_MAX_BLOCKS_ACROSS = 128;
	localparam int DEF_MAX_BLOCKS_DOWN   = 128;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_BLOCKS_ACROSS = 8'd40;
	localparam logic [CFG_W-1:0] RST_BLOCKS_DOWN   = 8'd30;

	// Register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_BLOCKS_ACROSS = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_BLOCKS_DOWN   = 1'b1;

	// Weighting: w = floor((255*sad + 1000) / 2000), taken as
	// floor(floor((255*sad + 1000) / 16) / 125) with a reciprocal multiply.
	localparam int SAD_CEILING = 2000;
	localparam int WEIGHT_TOP  = 255;
	localparam int ROUND_BIAS  = 1000;
	localparam int SAD_USED_W  = 11;
	localparam int NUM_W       = 19;
	localparam int NUM_SHIFT   = 4;
	localparam int SCALED_W    = NUM_W - NUM_SHIFT;
	localparam int RECIP_W     = 16;
	localparam int RECIP_SHIFT = 22;
	localparam logic [RECIP_W-1:0] RECIP_MUL = 16'd33555;
	localparam int WEIGHT_W    = 8;
	localparam int PROD_W      = WEIGHT_W + 1 + VEC_W;
	localparam longint PROD_MAX = longint'(WEIGHT_TOP) * 128;

	// Result limit
	localparam int MEAN_LIMIT = 4080;

	typedef struct packed {
		logic accept;     // input transaction this cycle
		logic load;       // capture sums and divisor, clear sums
		logic div_start;  // start one division
		logic div_sel;    // 0: x sum, 1: y sum
		logic keep_x;     // hold the x quotient
		logic out_load;   // load the result register
	} cmd_t;

	typedef struct packed {
		logic frame_end;  // current record is the padding record of the last row
		logic pipe_empty; // no weighted product still in flight
		logic div_done;   // divider finished this cycle
		logic out_free;   // result register can take a new result
	} status_t;

endpackage
`default_nettype wire

/* rtl/core/wgma_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgma_div: restoring unsigned divider
// Produces one quotient bit per clock while busy.
// ----------------------------------------------------------------------------
module wgma_div #(
	parameter int N_W  = 30,
	parameter int DV_W = 20
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [N_W-1:0]  dividend,
	input  wire logic [DV_W-1:0] divisor,
	output logic                 done,
	output logic [N_W-1:0]       quotient
);
	localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DV_W-1:0]  rem_q;
	logic [DV_W-1:0]  dvs_q;
	logic [N_W-1:0]   sh_q;
	logic [DV_W:0]    trial;
	logic             fits;

	assign trial = {rem_q, sh_q[N_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			sh_q  <= dividend;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract where the divisor fits
			rem_q <= fits ? DV_W'(trial - {1'b0, dvs_q}) : trial[DV_W-1:0];
			sh_q  <= {sh_q[N_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule
`default_nettype wire

/* rtl/core/wgma_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgma_datapath: weighting pipeline, sums, position counters and result
// Three-stage weight pipeline feeding two signed sums; frame-end division
// through one shared divider and a registered result stage.
// ----------------------------------------------------------------------------
module wgma_datapath #(
	parameter int MAX_BLOCKS_ACROSS = 128,
	parameter int MAX_BLOCKS_DOWN   = 128
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire wgma_pkg::cmd_t                   cmd,
	output wgma_pkg::status_t                     status,
	input  wire logic                             cfg_we,
	input  wire logic [wgma_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [wgma_pkg::CFG_W-1:0]       cfg_wdata,
	input  wire logic [wgma_pkg::S_TDATA_W-1:0]   s_tdata,
	input  wire logic                             m_tready,
	output logic                                  m_tvalid,
	output logic [wgma_pkg::M_TDATA_W-1:0]        m_tdata
);
	import wgma_pkg::*;

	localparam int DIM_W  = 9;
	localparam int A_W    = $clog2(MAX_BLOCKS_ACROSS + 1);
	localparam int D_W    = $clog2(MAX_BLOCKS_DOWN + 1);
	localparam int COL_W  = A_W;
	localparam int ROW_W  = (MAX_BLOCKS_DOWN > 1) ? $clog2(MAX_BLOCKS_DOWN) : 1;
	localparam int SUM_W  =
		$clog2(longint'(MAX_BLOCKS_ACROSS) * MAX_BLOCKS_DOWN * PROD_MAX + 1) + 1;
	localparam int DIVR_W = $clog2(8 * MAX_BLOCKS_ACROSS * MAX_BLOCKS_DOWN + 1);

	// Configuration
	logic [CFG_W-1:0] blocks_across_q;
	logic [CFG_W-1:0] blocks_down_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_across_q <= RST_BLOCKS_ACROSS;
			blocks_down_q   <= RST_BLOCKS_DOWN;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_BLOCKS_ACROSS: blocks_across_q <= cfg_wdata;
				REG_BLOCKS_DOWN:   blocks_down_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clamp the dimensions to 1..MAX
	logic [A_W-1:0] across_c;
	logic [D_W-1:0] down_c;

	always_comb begin
		if (blocks_across_q == '0)
			across_c = A_W'(1);
		else if (DIM_W'(blocks_across_q) > DIM_W'(MAX_BLOCKS_ACROSS))
			across_c = A_W'(MAX_BLOCKS_ACROSS);
		else
			across_c = A_W'(blocks_across_q);
		if (blocks_down_q == '0)
			down_c = D_W'(1);
		else if (DIM_W'(blocks_down_q) > DIM_W'(MAX_BLOCKS_DOWN))
			down_c = D_W'(MAX_BLOCKS_DOWN);
		else
			down_c = D_W'(blocks_down_q);
	end

	// Input fields
	logic signed [VEC_W-1:0] vector_x;
	logic signed [VEC_W-1:0] vector_y;
	logic [SAD_W-1:0]        block_sad;

	assign vector_x  = s_tdata[VEC_W-1:0];
	assign vector_y  = s_tdata[2*VEC_W-1:VEC_W];
	assign block_sad = s_tdata[2*VEC_W+SAD_W-1:2*VEC_W];

	// Position in the frame
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             is_pad;
	logic             last_row;

	assign is_pad   = DIM_W'(col_q) >= DIM_W'(across_c);
	assign last_row = (DIM_W'(row_q) + DIM_W'(1)) >= DIM_W'(down_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.accept) begin
			if (!is_pad) begin
				col_q <= col_q + COL_W'(1);
			end else begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end
		end
	end

	// Stage 1: eligibility and scaled numerator
	logic                    use_rec;
	logic [NUM_W-1:0]        num;
	logic                    v_s1;
	logic [SCALED_W-1:0]     n_s1;
	logic signed [VEC_W-1:0] vx_s1;
	logic signed [VEC_W-1:0] vy_s1;

	assign use_rec = !is_pad && (vector_x != '0 || vector_y != '0)
		&& block_sad <= SAD_W'(SAD_CEILING);
	assign num = NUM_W'(block_sad[SAD_USED_W-1:0]) * NUM_W'(WEIGHT_TOP)
		+ NUM_W'(ROUND_BIAS);

	// Stage 2: weight by reciprocal multiply
	logic [SCALED_W+RECIP_W-1:0] recip_prod;
	logic                        v_s2;
	logic [WEIGHT_W-1:0]         w_s2;
	logic signed [VEC_W-1:0]     vx_s2;
	logic signed [VEC_W-1:0]     vy_s2;

	assign recip_prod = (SCALED_W+RECIP_W)'(n_s1) * (SCALED_W+RECIP_W)'(RECIP_MUL);

	// Stage 3: weighted vectors
	logic signed [PROD_W-1:0] px;
	logic signed [PROD_W-1:0] py;
	logic                     v_s3;
	logic signed [PROD_W-1:0] px_s3;
	logic signed [PROD_W-1:0] py_s3;

	assign px = $signed({1'b0, w_s2}) * vx_s2;
	assign py = $signed({1'b0, w_s2}) * vy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.accept && use_rec;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		n_s1  <= num[NUM_W-1:NUM_SHIFT];
		vx_s1 <= vector_x;
		vy_s1 <= vector_y;
		w_s2  <= recip_prod[RECIP_SHIFT +: WEIGHT_W];
		vx_s2 <= vx_s1;
		vy_s2 <= vy_s1;
		px_s3 <= px;
		py_s3 <= py;
	end

	// Sums
	logic signed [SUM_W-1:0] sum_x_q;
	logic signed [SUM_W-1:0] sum_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (cmd.load) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
		end else if (v_s3) begin
			sum_x_q <= sum_x_q + SUM_W'(px_s3);
			sum_y_q <= sum_y_q + SUM_W'(py_s3);
		end
	end

	// Frame-end capture: magnitudes, signs and divisor
	logic [SUM_W-1:0]       mag_x_q;
	logic [SUM_W-1:0]       mag_y_q;
	logic                   neg_x_q;
	logic                   neg_y_q;
	logic [DIVR_W-1:0]      divisor_q;
	logic [A_W+D_W-1:0]     blocks;

	assign blocks = (A_W+D_W)'(across_c) * (A_W+D_W)'(down_c);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_x_q   <= sum_x_q[SUM_W-1] ? SUM_W'(-sum_x_q) : SUM_W'(sum_x_q);
			mag_y_q   <= sum_y_q[SUM_W-1] ? SUM_W'(-sum_y_q) : SUM_W'(sum_y_q);
			neg_x_q   <= sum_x_q[SUM_W-1];
			neg_y_q   <= sum_y_q[SUM_W-1];
			divisor_q <= DIVR_W'({blocks, 3'b000});
		end
	end

	// Shared divider
	logic             div_done;
	logic [SUM_W-1:0] quotient;
	logic [SUM_W-1:0] qx_q;

	wgma_div #(
		.N_W  (SUM_W),
		.DV_W (DIVR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cmd.div_sel ? mag_y_q : mag_x_q),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (cmd.keep_x)
			qx_q <= quotient;
	end

	function automatic logic [MEAN_W-1:0] finish_mean(
		input logic [SUM_W-1:0] q,
		input logic             neg
	);
		logic [MEAN_W-1:0] m;
		m = (q > SUM_W'(MEAN_LIMIT)) ? MEAN_W'(MEAN_LIMIT) : q[MEAN_W-1:0];
		return neg ? MEAN_W'(-m) : m;
	endfunction

	// Result register
	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load)
			out_data_q <= {(M_TDATA_W - 2*MEAN_W)'(0),
				finish_mean(quotient, neg_y_q), finish_mean(qx_q, neg_x_q)};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign status.frame_end  = is_pad && last_row;
	assign status.pipe_empty = !v_s1 && !v_s2 && !v_s3;
	assign status.div_done   = div_done;
	assign status.out_free   = !out_valid_q || m_tready;

endmodule
`default_nettype wire

/* rtl/core/wgma_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wgma_ctrl: frame sequencer
// Takes records during a frame, then drains the weight pipeline, runs the
// x and y divisions and hands the result to the output register.
// ----------------------------------------------------------------------------
module wgma_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire wgma_pkg::status_t status,
	output wgma_pkg::cmd_t         cmd
);
	import wgma_pkg::*;

	localparam logic [2:0] ST_RUN    = 3'd0;
	localparam logic [2:0] ST_DRAIN  = 3'd1;
	localparam logic [2:0] ST_STARTX = 3'd2;
	localparam logic [2:0] ST_WAITX  = 3'd3;
	localparam logic [2:0] ST_STARTY = 3'd4;
	localparam logic [2:0] ST_WAITY  = 3'd5;
	localparam logic [2:0] ST_RESULT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_RUN;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		s_tready      = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				if (s_tvalid && status.frame_end)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// wait for the last products to land in the sums
				if (status.pipe_empty) begin
					cmd.load = 1'b1;
					state_d  = ST_STARTX;
				end
			end
			ST_STARTX: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAITX;
			end
			ST_WAITX: begin
				if (status.div_done) begin
					cmd.keep_x = 1'b1;
					state_d    = ST_STARTY;
				end
			end
			ST_STARTY: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = 1'b1;
				state_d       = ST_WAITY;
			end
			ST_WAITY: begin
				cmd.div_sel = 1'b1;
				if (status.div_done)
					state_d = ST_RESULT;
			end
			ST_RESULT: begin
				// hold until the result register is free
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/weighted_global_motion_average_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_global_motion_average_unit: SAD-weighted global motion mean
// Accumulates weighted macroblock motion vectors over a frame and reports
// the mean x and y motion once per frame.
// ----------------------------------------------------------------------------
// Records are taken one per clock while a frame runs. Each row ends with a
// padding record; the padding record of the last row closes the frame, after
// which the block takes no record while it works out the means: it drains the
// weighting pipeline, then one restoring divider, one quotient bit per clock,
// divides the x sum and then the y sum (SUM_W = 30 bits with the default
// limits) by 8*blocks_across*blocks_down, and the result is loaded into an
// output register. The result then sits there until taken, while the next
// frame's records flow in; if an earlier result is still waiting when the
// next one is ready, the block holds there.
// ----------------------------------------------------------------------------
module weighted_global_motion_average_unit #(
	parameter int MAX_BLOCKS_ACROSS = wgma_pkg::DEF_MAX_BLOCKS_ACROSS,
	parameter int MAX_BLOCKS_DOWN   = wgma_pkg::DEF_MAX_BLOCKS_DOWN
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [wgma_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [wgma_pkg::CFG_W-1:0]       cfg_wdata,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	// vector_x [7:0], vector_y [15:8], block_sad [31:16]
	input  wire logic [wgma_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	// mean_x [12:0], mean_y [25:13], zeros [31:26]
	output logic [wgma_pkg::M_TDATA_W-1:0]        m_tdata
);
	import wgma_pkg::*;

	cmd_t    cmd;
	status_t status;

	wgma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	wgma_datapath #(
		.MAX_BLOCKS_ACROSS (MAX_BLOCKS_ACROSS),
		.MAX_BLOCKS_DOWN   (MAX_BLOCKS_DOWN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule
`default_nettype wire
